FILE: hw/rtl/tpq_pkg.sv
// Shared types and constants for the three-level priority queue.
package tpq_pkg;

    localparam int unsigned NUM_LEVELS      = 3;
    localparam int unsigned LEVEL_DEPTH_DEF = 16;
    localparam int unsigned DATA_W          = 32;
    localparam int unsigned LEVEL_W         = 2;

    // Word returned on every enqueue and on a dequeue that finds nothing.
    localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_BADLEVEL = 2'd3
    } t_status;

endpackage

FILE: hw/rtl/tpq_mem.sv
// Word store shared by the three levels: one write port, one registered read port.
module tpq_mem #(
    parameter int unsigned LEVEL_DEPTH = tpq_pkg::LEVEL_DEPTH_DEF,
    localparam int unsigned ADDR_W = $clog2(tpq_pkg::NUM_LEVELS * LEVEL_DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [ADDR_W-1:0]           i_wr_addr,
    input  logic [tpq_pkg::DATA_W-1:0]  i_wr_data,
    input  logic                        i_rd_en,
    input  logic [ADDR_W-1:0]           i_rd_addr,
    output logic [tpq_pkg::DATA_W-1:0]  o_rd_data
);
    import tpq_pkg::*;

    localparam int unsigned MEM_DEPTH = NUM_LEVELS * LEVEL_DEPTH;

    logic [DATA_W-1:0] r_mem [MEM_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read, so a stalled result keeps its word.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/three_level_priority_fifo.sv
// Top level of the three-level strict-priority queue.
//
// Usage: the input channel (i_in_valid / o_in_stall) carries one item per
// handshake: an opcode, a 32-bit value and a priority level. An enqueue
// appends the value to the FIFO of its level (1 highest, 3 lowest); a
// dequeue removes the head of the highest level that holds a word.
// Every item produces exactly one result item on the output channel
// (o_out_valid / i_out_stall) with the dequeued word and a status code:
// ok, level full (word dropped), all levels empty, or invalid level.
// The result is registered: the result of an item accepted at one edge is
// presented right after that edge. Throughput is one item per cycle while
// the receiver does not stall; the queue bookkeeping and the store access
// for an item both complete in the cycle it is accepted, using the single
// write and single read port of the word store.
// Reset (synchronous, active low) empties all three levels and drops any
// pending result; the word store itself is not cleared, since only words
// that were written are ever read.
// When the receiver stalls, the result register holds its item and the
// input channel stalls too; a new item is taken in the same cycle the
// held result leaves, so no cycle is lost to the handshake.
module three_level_priority_fifo #(
    parameter int unsigned LEVEL_DEPTH = tpq_pkg::LEVEL_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_opcode,
    input  logic signed [tpq_pkg::DATA_W-1:0]  i_value,
    input  logic [tpq_pkg::LEVEL_W-1:0]        i_level,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [tpq_pkg::DATA_W-1:0]  o_out_value,
    output logic [1:0]                         o_status
);
    import tpq_pkg::*;

    localparam int unsigned PTR_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int unsigned ADDR_W = $clog2(NUM_LEVELS * LEVEL_DEPTH);

    // Per-level queue bookkeeping.
    logic [CNT_W-1:0] r_cnt  [NUM_LEVELS];
    logic [CNT_W-1:0] n_cnt  [NUM_LEVELS];
    logic [PTR_W-1:0] r_head [NUM_LEVELS];
    logic [PTR_W-1:0] n_head [NUM_LEVELS];
    logic [PTR_W-1:0] r_tail [NUM_LEVELS];
    logic [PTR_W-1:0] n_tail [NUM_LEVELS];

    // Result register.
    logic    r_out_valid;
    logic    n_out_valid;
    t_status r_status;
    t_status n_status;
    logic    r_use_data;
    logic    n_use_data;

    logic                  in_acc;
    logic                  is_enq;
    logic [NUM_LEVELS-1:0] lvl_sel;
    logic [NUM_LEVELS-1:0] lvl_full;
    logic [NUM_LEVELS-1:0] lvl_busy;
    logic [NUM_LEVELS-1:0] deq_sel;
    logic [NUM_LEVELS-1:0] enq_go;
    logic [NUM_LEVELS-1:0] deq_go;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [DATA_W-1:0]     rd_data;

    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // A new item may enter whenever the result register is free or is being
    // emptied in this cycle.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_enq     = (t_opcode'(i_opcode) == OP_ENQ);

    // Per-level flags and the strict priority pick for a dequeue.
    always_comb begin
        for (int lv = 0; lv < NUM_LEVELS; lv++) begin
            lvl_sel[lv]  = (i_level == LEVEL_W'(lv + 1));
            lvl_full[lv] = (r_cnt[lv] == CNT_W'(LEVEL_DEPTH));
            lvl_busy[lv] = (r_cnt[lv] != '0);
        end
        deq_sel[0] = lvl_busy[0];
        deq_sel[1] = !lvl_busy[0] && lvl_busy[1];
        deq_sel[2] = !lvl_busy[0] && !lvl_busy[1] && lvl_busy[2];
        enq_go = (in_acc && is_enq)  ? (lvl_sel & ~lvl_full) : '0;
        deq_go = (in_acc && !is_enq) ? deq_sel : '0;
    end

    // Each level owns a contiguous slice of the store.
    always_comb begin
        wr_addr = '0;
        rd_addr = '0;
        for (int lv = 0; lv < NUM_LEVELS; lv++) begin
            if (lvl_sel[lv]) begin
                wr_addr = wr_addr | (ADDR_W'(lv * LEVEL_DEPTH) + ADDR_W'(r_tail[lv]));
            end
            if (deq_sel[lv]) begin
                rd_addr = rd_addr | (ADDR_W'(lv * LEVEL_DEPTH) + ADDR_W'(r_head[lv]));
            end
        end
    end

    always_comb begin
        for (int lv = 0; lv < NUM_LEVELS; lv++) begin
            n_cnt[lv]  = r_cnt[lv];
            n_head[lv] = r_head[lv];
            n_tail[lv] = r_tail[lv];
            if (enq_go[lv]) begin
                n_cnt[lv]  = r_cnt[lv] + CNT_W'(1);
                n_tail[lv] = next_pos(r_tail[lv]);
            end else if (deq_go[lv]) begin
                n_cnt[lv]  = r_cnt[lv] - CNT_W'(1);
                n_head[lv] = next_pos(r_head[lv]);
            end
        end
    end

    // Status of the item being accepted.
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_use_data  = r_use_data;
        if (in_acc) begin
            n_out_valid = 1'b1;
            n_use_data  = 1'b0;
            if (is_enq) begin
                if (i_level == '0) begin
                    n_status = ST_BADLEVEL;
                end else if ((lvl_sel & lvl_full) != '0) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                end
            end else if (lvl_busy != '0) begin
                n_status   = ST_OK;
                n_use_data = 1'b1;
            end else begin
                n_status = ST_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int lv = 0; lv < NUM_LEVELS; lv++) begin
                r_cnt[lv]  <= '0;
                r_head[lv] <= '0;
                r_tail[lv] <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            for (int lv = 0; lv < NUM_LEVELS; lv++) begin
                r_cnt[lv]  <= n_cnt[lv];
                r_head[lv] <= n_head[lv];
                r_tail[lv] <= n_tail[lv];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_use_data <= n_use_data;
    end

    tpq_mem #(
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (enq_go != '0),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_value),
        .i_rd_en   (deq_go != '0),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_out_value = r_use_data ? rd_data : EMPTY_WORD;

`ifndef SYNTHESIS
    // No level ever holds more words than it has room for.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= CNT_W'(LEVEL_DEPTH) && r_cnt[1] <= CNT_W'(LEVEL_DEPTH)
        && r_cnt[2] <= CNT_W'(LEVEL_DEPTH))
        else $error("level fill count exceeds depth");

    // One item touches at most one level.
    a_one_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(enq_go | deq_go) <= 1)
        else $error("more than one level updated by one item");

    // A dequeue that finds every level empty reports it.
    a_empty_deq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !is_enq && lvl_busy == '0 |=> o_out_valid && r_status == ST_EMPTY)
        else $error("empty dequeue not reported");

    // An enqueue with level zero is rejected and leaves the queues alone.
    a_bad_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && is_enq && i_level == '0
        |=> o_out_valid && r_status == ST_BADLEVEL && $stable(r_cnt[0])
            && $stable(r_cnt[1]) && $stable(r_cnt[2]))
        else $error("invalid level not rejected");

    // The input side only stalls behind a held result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no pending result");
`endif

endmodule
